### hdl/mpdf_pkg.sv
// mpdf_pkg: shared types and constants for the mesh packet dedup and ttl filter
// used by every module in hdl except mpdf_ram; depends on nothing
package mpdf_pkg;

   localparam int CACHE_ENTRIES = 128;
   localparam int ID_BYTES      = 8;
   localparam int ID_WIDTH      = 8 * ID_BYTES;
   localparam int IDX_WIDTH     = $clog2(CACHE_ENTRIES);

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(CACHE_ENTRIES - 1);
   localparam logic [7:0] VERSION_RESET = 8'd1;

   typedef enum logic [1:0] {
      VERDICT_BAD_VERSION = 2'd0,
      VERDICT_DUPLICATE   = 2'd1,
      VERDICT_EXPIRED     = 2'd2,
      VERDICT_FORWARDED   = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic        mode;
      logic [63:0] packet_id;
      logic [7:0]  ttl_in;
      logic [7:0]  hops_in;
      logic [7:0]  version_in;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  ttl_out;
      logic [7:0]  hops_out;
      logic        send_ack;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic clear_scan;
      logic scan;
      logic decide;
      logic reply_bad;
   } cmd_type;

   typedef struct packed {
      logic version_ok;
      logic scan_last;
   } status_type;

endpackage

### hdl/mesh_packet_dedup_ttl_filter.sv
// mesh_packet_dedup_ttl_filter: top level, duplicate suppression and ttl filter
// depends on mpdf_pkg, mpdf_ctrl, mpdf_dp (which holds mpdf_ram)
//
//   channel   ports                         transfer when
//   request   start, busy, req_payload      start high and busy low at the edge
//   result    rsp_valid, rsp_payload        rsp_valid high for one cycle
//   config    csr_we, csr_wdata             csr_we high at the edge
//
// a neighbor packet with the wrong version is answered from the check state, without a cache scan
// any other packet scans all CACHE_ENTRIES entries of the id cache: the cache is read one
// entry per cycle through the single ram read port, then the verdict is registered
// busy drops in the cycle the result is shown, so a new request may enter then
// synchronous active-high reset clears the cache valid bits, the insert pointer and
// sets the expected version to 1; results cannot be stalled by the receiver
module mesh_packet_dedup_ttl_filter
   import mpdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_valid,
   output rsp_type    rsp_payload,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mpdf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mpdf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/mpdf_ram.sv
// mpdf_ram: generic single write port, single read port ram with registered read
// standalone; no package needed
module mpdf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/mpdf_ctrl.sv
// mpdf_ctrl: sequencing state machine for one packet header
// depends on mpdf_pkg; drives commands into mpdf_dp and reads its status
module mpdf_ctrl
   import mpdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.version_ok) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CHECK: begin
            cmd.clear_scan = status.version_ok;
            cmd.reply_bad  = !status.version_ok;
         end
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_DRAIN:  cmd        = '0;
         ST_DECIDE: cmd.decide = 1'b1;
         default:   busy       = 1'b1;
      endcase
   end

endmodule

### hdl/mpdf_dp.sv
// mpdf_dp: header register, id cache scan, valid bits, insert pointer and result register
// depends on mpdf_pkg and mpdf_ram
module mpdf_dp
   import mpdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_payload
);

   req_type                req_ff;
   logic [7:0]             version_ff;
   logic [IDX_WIDTH-1:0]   cnt_ff;
   logic [IDX_WIDTH-1:0]   ptr_ff;
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic                   vld_rd_ff;
   logic                   cmp_en_ff;
   logic                   hit_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [ID_WIDTH-1:0]    id;
   logic [ID_WIDTH-1:0]    rd_data;
   logic                   ram_we;

   assign id     = req_ff.packet_id[ID_WIDTH-1:0];
   assign ram_we = cmd.decide && !hit_ff;

   assign status.version_ok = req_ff.mode || (req_ff.version_in == version_ff);
   assign status.scan_last  = (cnt_ff == LAST_IDX);

   mpdf_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (CACHE_ENTRIES)
   ) u_id_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ptr_ff),
      .wdata (id),
      .raddr (cnt_ff),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      vld_rd_ff <= valid_ff[cnt_ff];
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff   <= VERSION_RESET;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         cmp_en_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            version_ff <= csr_wdata;
         end
         if (cmd.clear_scan) begin
            cnt_ff <= '0;
         end else if (cmd.scan) begin
            cnt_ff <= status.scan_last ? '0 : cnt_ff + 1'b1;
         end
         cmp_en_ff <= cmd.scan;
         if (cmd.clear_scan) begin
            hit_ff <= 1'b0;
         end else if (cmp_en_ff && vld_rd_ff && (rd_data == id)) begin
            hit_ff <= 1'b1;
         end
         if (ram_we) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.reply_bad || cmd.decide;
      end
   end

   always_comb begin
      rsp_in.verdict  = VERDICT_BAD_VERSION;
      rsp_in.ttl_out  = req_ff.ttl_in;
      rsp_in.hops_out = req_ff.hops_in;
      rsp_in.send_ack = 1'b0;
      if (cmd.decide) begin
         if (hit_ff) begin
            rsp_in.verdict = VERDICT_DUPLICATE;
         end else begin
            rsp_in.send_ack = req_ff.mode;
            if (req_ff.ttl_in <= 8'd1) begin
               rsp_in.verdict = VERDICT_EXPIRED;
            end else begin
               rsp_in.verdict  = VERDICT_FORWARDED;
               rsp_in.ttl_out  = req_ff.ttl_in - 8'd1;
               rsp_in.hops_out = req_ff.hops_in + 8'd1;
            end
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe lasted more than one cycle");

   a_record_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(ptr_ff)])
      else $error("recorded slot not marked valid");

   a_dup_no_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.verdict == VERDICT_DUPLICATE)) |-> !rsp_ff.send_ack)
      else $error("duplicate raised an acknowledge");

   a_fwd_ttl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.verdict == VERDICT_FORWARDED)) |-> (rsp_ff.ttl_out != 8'd0))
      else $error("forwarded packet carries zero ttl");

endmodule
